FILE: rtl/gih_pkg.sv
// package for the gamepad input history block
// commands, states, field widths, defaults and divider control; no dependencies
package gih_pkg;

  localparam int HISTORY_DEPTH_DEF = 16;
  localparam int NUM_AXES_DEF      = 8;
  localparam int NUM_BUTTONS_DEF   = 64;
  localparam int BTN_W             = 6;
  localparam int AXID_W            = 3;
  localparam int SAMPLE_W          = 16;
  localparam int BACK_W            = 4;
  localparam int MASK_W            = 64;

  typedef enum logic [2:0] {
    CMD_PRESS   = 3'd0,
    CMD_RELEASE = 3'd1,
    CMD_TICK    = 3'd2,
    CMD_AXWR    = 3'd3,
    CMD_BTNQ    = 3'd4,
    CMD_AXQ     = 3'd5,
    CMD_CAL     = 3'd6,
    CMD_NONE    = 3'd7
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_EDGE,
    ST_BQ,
    ST_TICK_RD,
    ST_TICK_WR,
    ST_AQ_RD,
    ST_AQ_CALC,
    ST_DIV,
    ST_DONE,
    ST_OUT
  } state_t;

  // divider control between top level and divider
  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;

endpackage

FILE: rtl/gih_ram.sv
// generic single-port synchronous ram with registered read
// no dependencies
module gih_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: rtl/gih_div.sv
// restoring serial divider, one quotient bit per cycle, unsigned operands
// uses gih_pkg for the control struct
module gih_div (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [31:0]      dividend,
  input  logic [16:0]      divisor,
  output gih_pkg::div_ctl_t ctl,
  output logic [31:0]      quotient
);

  logic [31:0] q_r, q_nxt;
  logic [17:0] rem_r, rem_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [17:0] trial;

  // load on start, else one shift and subtract step while busy
  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[16:0], q_r[31]};
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      cnt_nxt  = 6'd32;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = trial - {1'b0, divisor};
        q_nxt   = {q_r[30:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
  end

  assign ctl.start = start;
  assign ctl.busy  = busy_r;
  assign ctl.done  = done_r;
  assign quotient  = q_r;

endmodule

FILE: rtl/gamepad_input_history.sv
// gamepad input history: button and axis ring of per-frame state, one item at a time
// a frame tick copies the row, then reads and writes each axis; an axis query uses the
// 32-step divider, while an uncalibrated axis or a zero span is answered without it
// input waits while a result is held
// synchronous active-low reset clears frame index, valid bits and control; no clear pass
// dependencies: gih_pkg, gih_ram, gih_div
module gamepad_input_history #(
  parameter int HISTORY_DEPTH = gih_pkg::HISTORY_DEPTH_DEF,
  parameter int NUM_AXES      = gih_pkg::NUM_AXES_DEF,
  parameter int NUM_BUTTONS   = gih_pkg::NUM_BUTTONS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // cmd[2:0]
  input  logic [2:0]  in_tuser,
  // button_id[5:0], axis_id[8:6], axis_sample[24:9], frames_back[28:25],
  // cal_lower[44:29], cal_upper[60:45], cal_neutral[76:61], zero fill [79:77]
  input  logic [79:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // held_bit[0], pressed_bit[1], released_bit[2], axis_norm[18:3], zero fill [23:19]
  output logic [23:0] out_tdata,
  // uncalibrated[0], zero_span[1]
  output logic [1:0]  out_tuser
);

  localparam int FW  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int AW  = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
  localparam int AXD = HISTORY_DEPTH * NUM_AXES;
  localparam int AXW = $clog2(AXD);
  localparam int RW  = 3 * gih_pkg::MASK_W;

  gih_pkg::state_t state_r, state_nxt;

  // latched command fields
  logic [2:0]  cmd_r;
  logic [5:0]  btn_r;
  logic [2:0]  ax_r;
  logic [15:0] smp_r;
  logic [3:0]  back_r;

  logic [FW-1:0] cur_r, cur_nxt;
  logic [HISTORY_DEPTH-1:0] fvalid_r, fvalid_nxt;
  logic [AXD-1:0] avalid_r, avalid_nxt;
  logic [NUM_AXES-1:0] cen_r, cen_nxt;
  logic signed [15:0] cl_r [NUM_AXES];
  logic signed [15:0] cu_r [NUM_AXES];
  logic signed [15:0] cn_r [NUM_AXES];
  logic [AW:0] k_r, k_nxt;
  logic        out_v_r, out_v_nxt;
  logic [20:0] out_d_r, out_d_nxt;
  logic        neg_r, neg_nxt;
  logic signed [17:0] num_r, num_nxt;
  logic signed [17:0] span_r, span_nxt;

  // frame row ram: released, pressed, held
  logic          row_we;
  logic [FW-1:0] row_addr;
  logic [RW-1:0] row_wdata, row_rdata, row_eff;
  // axis ram
  logic           ax_we;
  logic [AXW-1:0] ax_addr;
  logic [15:0]    ax_wdata, ax_rdata, ax_eff;

  logic        div_start;
  logic [31:0] div_q;
  logic [31:0] div_dvd;
  logic [16:0] div_dvs;
  gih_pkg::div_ctl_t div_ctl;

  logic [FW-1:0] bmod;
  logic [FW-1:0] qframe;
  logic [FW-1:0] nxt_frame;
  logic          btn_ok, ax_ok;
  logic [AW-1:0] ax_idx;
  logic [AXW-1:0] cur_ax_addr;

  gih_ram #(.WIDTH(RW), .DEPTH(HISTORY_DEPTH)) u_row_ram (
    .clk(clk), .we(row_we), .addr(row_addr), .wdata(row_wdata), .rdata(row_rdata)
  );

  gih_ram #(.WIDTH(16), .DEPTH(AXD)) u_ax_ram (
    .clk(clk), .we(ax_we), .addr(ax_addr), .wdata(ax_wdata), .rdata(ax_rdata)
  );

  gih_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_dvd), .divisor(div_dvs),
    .ctl(div_ctl), .quotient(div_q)
  );

  // look-back modulo the ring depth as a constant table
  function automatic logic [FW-1:0] back_mod(input logic [3:0] b);
    logic [FW-1:0] r;
    r = '0;
    for (int i = 0; i < 16; i++) begin
      if (b == 4'(i)) r = FW'(i % HISTORY_DEPTH);
    end
    return r;
  endfunction

  function automatic logic [63:0] row_eff_cur_held(input logic [RW-1:0] r, input logic v);
    return v ? r[63:0] : 64'd0;
  endfunction

  assign bmod      = back_mod(back_r);
  assign qframe    = (cur_r >= bmod) ? cur_r - bmod
                     : FW'((FW+1)'(cur_r) + (FW+1)'(HISTORY_DEPTH) - (FW+1)'(bmod));
  assign nxt_frame = (cur_r == FW'(HISTORY_DEPTH - 1)) ? '0 : cur_r + 1'b1;
  assign btn_ok    = 32'(btn_r) < NUM_BUTTONS;
  assign ax_ok     = 32'(ax_r) < NUM_AXES;
  assign ax_idx    = AW'(ax_r);
  // unwritten entries read as zero
  assign row_eff   = fvalid_r[row_addr] ? row_rdata : '0;
  assign ax_eff    = avalid_r[ax_addr] ? ax_rdata : '0;
  assign cur_ax_addr = AXW'(32'(cur_r) * NUM_AXES + 32'(ax_idx));
  assign div_dvd   = {num_r[16:0], 15'd0};
  assign div_dvs   = span_r[16:0];

  // sequencer
  always_comb begin
    logic [63:0] bitm;
    logic [63:0] hm, pm, rm;
    logic signed [17:0] s, n, sp;
    logic [31:0] qmag;
    state_nxt  = state_r;
    cur_nxt    = cur_r;
    fvalid_nxt = fvalid_r;
    avalid_nxt = avalid_r;
    cen_nxt    = cen_r;
    k_nxt      = k_r;
    out_v_nxt  = out_v_r;
    out_d_nxt  = out_d_r;
    neg_nxt    = neg_r;
    num_nxt    = num_r;
    span_nxt   = span_r;
    row_we     = 1'b0;
    row_addr   = cur_r;
    row_wdata  = row_eff;
    ax_we      = 1'b0;
    ax_addr    = cur_ax_addr;
    ax_wdata   = smp_r;
    div_start  = 1'b0;
    bitm       = 64'd1 << btn_r;
    hm = row_eff[63:0];
    pm = row_eff[127:64];
    rm = row_eff[191:128];
    s  = '0; n = '0; sp = '0; qmag = '0;
    in_tready  = (state_r == gih_pkg::ST_IDLE) && !out_v_r;
    if (out_v_r && out_tready) out_v_nxt = 1'b0;
    unique case (state_r)
      gih_pkg::ST_IDLE: begin
        if (in_tvalid && in_tready) state_nxt = gih_pkg::ST_RD;
      end
      gih_pkg::ST_RD: begin
        unique case (gih_pkg::cmd_t'(cmd_r))
          gih_pkg::CMD_PRESS, gih_pkg::CMD_RELEASE: begin
            row_addr  = cur_r;
            state_nxt = btn_ok ? gih_pkg::ST_EDGE : gih_pkg::ST_IDLE;
          end
          gih_pkg::CMD_TICK: begin
            row_addr  = cur_r;
            state_nxt = gih_pkg::ST_TICK_RD;
          end
          gih_pkg::CMD_AXWR: begin
            if (ax_ok) begin
              ax_we = 1'b1;
              avalid_nxt[cur_ax_addr] = 1'b1;
            end
            state_nxt = gih_pkg::ST_IDLE;
          end
          gih_pkg::CMD_BTNQ: begin
            row_addr  = qframe;
            state_nxt = gih_pkg::ST_BQ;
          end
          gih_pkg::CMD_AXQ: begin
            if (!ax_ok || !cen_r[ax_idx]) begin
              out_d_nxt = 21'd1 << 19;
              out_v_nxt = 1'b1;
              state_nxt = gih_pkg::ST_IDLE;
            end else begin
              ax_addr   = AXW'(32'(qframe) * NUM_AXES + 32'(ax_idx));
              state_nxt = gih_pkg::ST_AQ_RD;
            end
          end
          default: state_nxt = gih_pkg::ST_IDLE;
        endcase
      end
      gih_pkg::ST_EDGE: begin
        row_addr = cur_r;
        if (cmd_r == gih_pkg::CMD_PRESS) begin
          pm = pm | bitm; hm = hm | bitm;
        end else begin
          rm = rm | bitm; hm = hm & ~bitm;
        end
        row_wdata = {rm, pm, hm};
        row_we    = 1'b1;
        fvalid_nxt[cur_r] = 1'b1;
        state_nxt = gih_pkg::ST_IDLE;
      end
      gih_pkg::ST_BQ: begin
        row_addr = qframe;
        out_d_nxt = '0;
        if (btn_ok) begin
          out_d_nxt[0] = hm[btn_r];
          out_d_nxt[1] = pm[btn_r];
          out_d_nxt[2] = rm[btn_r];
        end
        out_v_nxt = 1'b1;
        state_nxt = gih_pkg::ST_IDLE;
      end
      gih_pkg::ST_TICK_RD: begin
        // write next row: held copied, edges cleared
        row_addr  = cur_r;
        state_nxt = gih_pkg::ST_TICK_WR;
        k_nxt     = '0;
      end
      gih_pkg::ST_TICK_WR: begin
        // axis k: read here, written to the next frame in the following state
        if (k_r == (AW+1)'(NUM_AXES)) begin
          cur_nxt   = nxt_frame;
          state_nxt = gih_pkg::ST_IDLE;
        end else begin
          ax_addr = AXW'(32'(cur_r) * NUM_AXES + 32'(k_r[AW-1:0]));
          state_nxt = gih_pkg::ST_DONE;
        end
      end
      gih_pkg::ST_DONE: begin
        ax_addr  = AXW'(32'(nxt_frame) * NUM_AXES + 32'(k_r[AW-1:0]));
        ax_we    = 1'b1;
        avalid_nxt[ax_addr] = 1'b1;
        ax_wdata = avalid_r[AXW'(32'(cur_r) * NUM_AXES + 32'(k_r[AW-1:0]))] ? ax_rdata : '0;
        k_nxt    = k_r + 1'b1;
        state_nxt = gih_pkg::ST_TICK_WR;
      end
      gih_pkg::ST_AQ_RD: begin
        ax_addr = AXW'(32'(qframe) * NUM_AXES + 32'(ax_idx));
        s  = 18'(signed'(ax_eff));
        n  = 18'(cn_r[ax_idx]);
        sp = (s > n) ? 18'(cu_r[ax_idx]) - n : n - 18'(cl_r[ax_idx]);
        num_nxt  = s - n;
        span_nxt = sp;
        state_nxt = gih_pkg::ST_AQ_CALC;
      end
      gih_pkg::ST_AQ_CALC: begin
        if (span_r == '0) begin
          out_d_nxt = 21'd1 << 20;
          out_v_nxt = 1'b1;
          state_nxt = gih_pkg::ST_IDLE;
        end else begin
          neg_nxt  = num_r[17] ^ span_r[17];
          num_nxt  = num_r[17] ? -num_r : num_r;
          span_nxt = span_r[17] ? -span_r : span_r;
          state_nxt = gih_pkg::ST_OUT;
        end
      end
      gih_pkg::ST_OUT: begin
        div_start = 1'b1;
        state_nxt = gih_pkg::ST_DIV;
      end
      gih_pkg::ST_DIV: begin
        if (div_ctl.done) begin
          qmag = div_q;
          out_d_nxt = '0;
          if (neg_r) out_d_nxt[18:3] = (qmag >= 32'd32768) ? 16'h8000 : 16'(-qmag);
          else       out_d_nxt[18:3] = (qmag >= 32'd32767) ? 16'h7fff : qmag[15:0];
          out_v_nxt = 1'b1;
          state_nxt = gih_pkg::ST_IDLE;
        end
      end
      default: state_nxt = gih_pkg::ST_IDLE;
    endcase
    if (state_r == gih_pkg::ST_TICK_RD) begin
      row_addr  = nxt_frame;
      row_we    = 1'b1;
      row_wdata = {128'd0, row_eff_cur_held(row_rdata, fvalid_r[cur_r])};
      fvalid_nxt[nxt_frame] = 1'b1;
    end
    if (state_r == gih_pkg::ST_RD && cmd_r == gih_pkg::CMD_CAL && ax_ok)
      cen_nxt[ax_idx] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= gih_pkg::ST_IDLE;
      cur_r    <= '0;
      fvalid_r <= '0;
      avalid_r <= '0;
      cen_r    <= '0;
      out_v_r  <= 1'b0;
      k_r      <= '0;
    end else begin
      state_r  <= state_nxt;
      cur_r    <= cur_nxt;
      fvalid_r <= fvalid_nxt;
      avalid_r <= avalid_nxt;
      cen_r    <= cen_nxt;
      out_v_r  <= out_v_nxt;
      k_r      <= k_nxt;
    end
    out_d_r <= out_d_nxt;
    neg_r   <= neg_nxt;
    num_r   <= num_nxt;
    span_r  <= span_nxt;
    if (in_tvalid && in_tready) begin
      cmd_r  <= in_tuser;
      btn_r  <= in_tdata[5:0];
      ax_r   <= in_tdata[8:6];
      smp_r  <= in_tdata[24:9];
      back_r <= in_tdata[28:25];
    end
    if (in_tvalid && in_tready && in_tuser == gih_pkg::CMD_CAL &&
        32'(in_tdata[8:6]) < NUM_AXES) begin
      cl_r[AW'(in_tdata[8:6])] <= in_tdata[44:29];
      cu_r[AW'(in_tdata[8:6])] <= in_tdata[60:45];
      cn_r[AW'(in_tdata[8:6])] <= in_tdata[76:61];
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {5'd0, out_d_r[18:0]};
  assign out_tuser  = out_d_r[20:19];

endmodule

FILE: rtl/gih_checker.sv
// port-level checker for the gamepad input history block
// bound to gamepad_input_history; uses no package
module gih_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic [1:0]  out_tuser
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // no input taken while a result waits
  a_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("input taken while result pending");

  // flags exclusive in any result
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[0] && out_tuser[1])) else $error("both flags set");

  // flagged result carries zero value
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[0] || out_tuser[1]) |-> out_tdata[18:0] == 19'd0)
    else $error("flagged result nonzero");

endmodule

bind gamepad_input_history gih_checker u_gih_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .out_tuser(out_tuser)
);

FILE: tb/sv/tb_gamepad_input_history.sv
// testbench for gamepad_input_history: directed and random command streams
// checked against an in-bench model of the button/axis history; depends on gih_pkg
`timescale 1ns / 100ps

module tb_gamepad_input_history;
  import gih_pkg::*;

  localparam int DEPTH = HISTORY_DEPTH_DEF;
  localparam int NAX   = NUM_AXES_DEF;

  typedef struct packed {
    logic               zero_span;
    logic               uncalibrated;
    logic signed [15:0] axis_norm;
    logic               released_bit;
    logic               pressed_bit;
    logic               held_bit;
  } query_res_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [2:0]  in_tuser;
  logic [79:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic [1:0]  out_tuser;

  // model state
  logic [3:0]         cur_frame;
  logic [63:0]        held_ring [DEPTH];
  logic [63:0]        press_ring[DEPTH];
  logic [63:0]        rel_ring  [DEPTH];
  logic signed [15:0] axis_ring [DEPTH][NAX];
  logic               cal_on    [NAX];
  logic signed [15:0] cal_lo    [NAX];
  logic signed [15:0] cal_hi    [NAX];
  logic signed [15:0] cal_mid   [NAX];

  query_res_t pending_results[$];
  int  n_fail;
  bit  stall_en;     // random receiver stalls
  bit  send_gaps;    // random sender gaps
  bit  hold_off;     // long receiver hold-off request

  gamepad_input_history u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tuser(in_tuser), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  always begin
    clk = 1'b0; #1;
    clk = 1'b1; #1;
  end

  // history model update; returns 1 and fills res when a result is due
  function automatic bit predict_history(input cmd_t cmd, input logic [5:0] btn,
                                         input logic [2:0] ax,
                                         input logic signed [15:0] smp,
                                         input logic [3:0] back,
                                         input logic signed [15:0] lo,
                                         input logic signed [15:0] hi,
                                         input logic signed [15:0] mid,
                                         output query_res_t res);
    logic [3:0] nxt;
    logic [3:0] f;
    int s;
    int n;
    int span;
    longint q;
    res = '0;
    f = cur_frame - back;
    case (cmd)
      CMD_PRESS: begin
        press_ring[cur_frame][btn] = 1'b1;
        held_ring[cur_frame][btn]  = 1'b1;
      end
      CMD_RELEASE: begin
        rel_ring[cur_frame][btn]  = 1'b1;
        held_ring[cur_frame][btn] = 1'b0;
      end
      CMD_TICK: begin
        nxt = cur_frame + 4'd1;
        press_ring[nxt] = '0;
        rel_ring[nxt]   = '0;
        held_ring[nxt]  = held_ring[cur_frame];
        for (int k = 0; k < NAX; k++) axis_ring[nxt][k] = axis_ring[cur_frame][k];
        cur_frame = nxt;
      end
      CMD_AXWR: axis_ring[cur_frame][ax] = smp;
      CMD_BTNQ: begin
        res.held_bit     = held_ring[f][btn];
        res.pressed_bit  = press_ring[f][btn];
        res.released_bit = rel_ring[f][btn];
        return 1'b1;
      end
      CMD_AXQ: begin
        if (!cal_on[ax]) begin
          res.uncalibrated = 1'b1;
          return 1'b1;
        end
        s = axis_ring[f][ax];
        n = cal_mid[ax];
        span = (s > n) ? int'(cal_hi[ax]) - n : n - int'(cal_lo[ax]);
        if (span == 0) begin
          res.zero_span = 1'b1;
          return 1'b1;
        end
        q = (longint'(s - n) * 32768) / longint'(span);
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        res.axis_norm = 16'(q);
        return 1'b1;
      end
      CMD_CAL: begin
        cal_on[ax]  = 1'b1;
        cal_lo[ax]  = lo;
        cal_hi[ax]  = hi;
        cal_mid[ax] = mid;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  // send one item and record what it should produce
  task automatic send_item(input cmd_t cmd, input logic [5:0] btn, input logic [2:0] ax,
                           input logic [15:0] smp, input logic [3:0] back,
                           input logic [15:0] lo, input logic [15:0] hi,
                           input logic [15:0] mid);
    query_res_t r;
    if (send_gaps && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_tdata  <= {3'd0, mid, hi, lo, back, smp, ax, btn};
    in_tuser  <= cmd;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (predict_history(cmd, btn, ax, smp, back, lo, hi, mid, r))
      pending_results.push_back(r);
    @(negedge clk);
  endtask

  task automatic send_random_item(input bit noisy);
    cmd_t c;
    logic [3:0] back;
    int pick;
    pick = $urandom_range(0, 99);
    if (noisy) c = cmd_t'($urandom_range(0, 7));
    else if (pick < 25) c = CMD_PRESS;
    else if (pick < 40) c = CMD_RELEASE;
    else if (pick < 50) c = CMD_TICK;
    else if (pick < 62) c = CMD_AXWR;
    else if (pick < 78) c = CMD_BTNQ;
    else if (pick < 94) c = CMD_AXQ;
    else c = CMD_CAL;
    back = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(0, 3));
    send_item(c, 6'($urandom), 3'($urandom), 16'($urandom), back,
              16'($urandom_range(0, 1) ? $urandom : -$urandom_range(0, 300) - 16'd30000),
              16'($urandom_range(0, 1) ? $urandom : $urandom_range(29000, 32767)),
              16'($urandom_range(0, 1) ? $urandom : $urandom_range(0, 400) - 200));
  endtask

  task automatic test_buttons();
    send_item(CMD_BTNQ, 6'd0, 3'd0, '0, 4'd0, '0, '0, '0);
    send_item(CMD_PRESS, 6'd0, 3'd0, '0, 4'd0, '0, '0, '0);
    send_item(CMD_PRESS, 6'd63, 3'd0, '0, 4'd0, '0, '0, '0);
    send_item(CMD_RELEASE, 6'd0, 3'd0, '0, 4'd0, '0, '0, '0);
    send_item(CMD_BTNQ, 6'd0, 3'd0, '0, 4'd0, '0, '0, '0);
    send_item(CMD_BTNQ, 6'd63, 3'd0, '0, 4'd0, '0, '0, '0);
    send_item(CMD_TICK, 6'd0, 3'd0, '0, 4'd0, '0, '0, '0);
    send_item(CMD_BTNQ, 6'd63, 3'd0, '0, 4'd0, '0, '0, '0);
    // look-back wraps around the ring
    send_item(CMD_BTNQ, 6'd63, 3'd0, '0, 4'd15, '0, '0, '0);
    send_item(CMD_BTNQ, 6'd0, 3'd0, '0, 4'd1, '0, '0, '0);
    // unused command does nothing
    send_item(CMD_NONE, 6'd63, 3'd7, 16'hffff, 4'hf, 16'hffff, 16'hffff, 16'hffff);
  endtask

  task automatic test_axes();
    // uncalibrated axis
    send_item(CMD_AXQ, 6'd0, 3'd7, '0, 4'd0, '0, '0, '0);
    send_item(CMD_CAL, 6'd0, 3'd7, '0, 4'd0, 16'h8000, 16'h7fff, 16'h0000);
    send_item(CMD_AXWR, 6'd0, 3'd7, 16'h7fff, 4'd0, '0, '0, '0);
    send_item(CMD_AXQ, 6'd0, 3'd7, '0, 4'd0, '0, '0, '0);
    send_item(CMD_AXWR, 6'd0, 3'd7, 16'h8000, 4'd0, '0, '0, '0);
    send_item(CMD_AXQ, 6'd0, 3'd7, '0, 4'd0, '0, '0, '0);
    // zero span at neutral sample
    send_item(CMD_CAL, 6'd0, 3'd0, '0, 4'd0, 16'h0000, 16'h0000, 16'h0000);
    send_item(CMD_AXQ, 6'd0, 3'd0, '0, 4'd0, '0, '0, '0);
    // negative span and saturation
    send_item(CMD_CAL, 6'd0, 3'd1, '0, 4'd0, 16'h0010, 16'hff00, 16'h0000);
    send_item(CMD_AXWR, 6'd0, 3'd1, 16'h0005, 4'd0, '0, '0, '0);
    send_item(CMD_AXQ, 6'd0, 3'd1, '0, 4'd0, '0, '0, '0);
    send_item(CMD_AXWR, 6'd0, 3'd1, 16'h8000, 4'd0, '0, '0, '0);
    send_item(CMD_AXQ, 6'd0, 3'd1, '0, 4'd0, '0, '0, '0);
    send_item(CMD_TICK, 6'd0, 3'd0, '0, 4'd0, '0, '0, '0);
    send_item(CMD_AXQ, 6'd0, 3'd7, '0, 4'd1, '0, '0, '0);
  endtask

  // long receiver hold-off while items keep coming
  task automatic test_backpressure();
    hold_off = 1'b1;
    for (int i = 0; i < 20; i++)
      send_item(CMD_BTNQ, 6'($urandom), 3'd0, '0, 4'($urandom), '0, '0, '0);
  endtask

  task automatic test_random(input int count, input bit gaps);
    stall_en  = gaps;
    send_gaps = gaps;
    for (int i = 0; i < count; i++) send_random_item($urandom_range(0, 19) == 0);
  endtask

  // receiver readiness
  initial begin
    int hold_left;
    out_tready = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        hold_off = 1'b0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (stall_en && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 7) - 1) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    query_res_t got;
    query_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = query_res_t'({out_tuser, out_tdata[18:0]});
      if (pending_results.size() == 0) begin
        $error("unexpected result %h %h", out_tuser, out_tdata);
        n_fail++;
      end else begin
        want = pending_results.pop_front();
        if (got.held_bit !== want.held_bit) begin
          $error("held_bit exp %0d got %0d", want.held_bit, got.held_bit); n_fail++;
        end
        if (got.pressed_bit !== want.pressed_bit) begin
          $error("pressed_bit exp %0d got %0d", want.pressed_bit, got.pressed_bit); n_fail++;
        end
        if (got.released_bit !== want.released_bit) begin
          $error("released_bit exp %0d got %0d", want.released_bit, got.released_bit);
          n_fail++;
        end
        if (got.axis_norm !== want.axis_norm) begin
          $error("axis_norm exp %0d got %0d", want.axis_norm, got.axis_norm); n_fail++;
        end
        if (got.uncalibrated !== want.uncalibrated) begin
          $error("uncalibrated exp %0d got %0d", want.uncalibrated, got.uncalibrated);
          n_fail++;
        end
        if (got.zero_span !== want.zero_span) begin
          $error("zero_span exp %0d got %0d", want.zero_span, got.zero_span); n_fail++;
        end
      end
    end
  end

  // run limit
  initial begin
    #2000000;
    $display("tb_gamepad_input_history NOT OK");
    $finish;
  end

  initial begin
    int guard;
    n_fail = 0;
    stall_en = 1'b0;
    send_gaps = 1'b0;
    hold_off = 1'b0;
    in_tvalid = 1'b0;
    in_tuser = '0;
    in_tdata = '0;
    rst_n = 1'b0;
    cur_frame = '0;
    for (int i = 0; i < DEPTH; i++) begin
      held_ring[i] = '0; press_ring[i] = '0; rel_ring[i] = '0;
      for (int k = 0; k < NAX; k++) axis_ring[i][k] = '0;
    end
    for (int k = 0; k < NAX; k++) begin
      cal_on[k] = 1'b0; cal_lo[k] = '0; cal_hi[k] = '0; cal_mid[k] = '0;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_buttons();
    test_axes();
    test_backpressure();
    test_random(1000, 1'b1);
    test_random(300, 1'b0);
    in_tvalid <= 1'b0;

    guard = 0;
    while (pending_results.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (100) @(posedge clk);
    if (n_fail == 0 && pending_results.size() == 0) begin
      $display("tb_gamepad_input_history OK");
    end else begin
      $display("tb_gamepad_input_history NOT OK");
    end
    $finish;
  end

endmodule

FILE: gamepad_input_history.f
rtl/gih_pkg.sv
rtl/gih_ram.sv
rtl/gih_div.sv
rtl/gamepad_input_history.sv
rtl/gih_checker.sv
tb/sv/tb_gamepad_input_history.sv
